>>> rtl/dlar_pkg.sv
// Package for the dual-line ADC readout sequencer.
// Holds the shared widths, the action codes, the configuration register
// indexes and the structs that pass between modules. No dependencies.
`default_nettype none

package dlar_pkg;

    // Number of ADC devices on the shared readout bus.
    localparam int NumDevices = 4;
    // The busy and chip select fields are four bits wide, so at most four
    // devices can be served, and at least one always is.
    localparam int DevCount = (NumDevices > 4) ? 4 : ((NumDevices < 1) ? 1 : NumDevices);

    localparam int WordBits    = 16;
    localparam int WordsPerDev = 4;
    localparam int CfgWidth    = 3;
    localparam int CfgIdxWidth = 1;

    // Input action codes.
    typedef enum logic [1:0] {
        ACT_TICK     = 2'd0,
        ACT_START_ALL = 2'd1,
        ACT_START_ONE = 2'd2,
        ACT_RESERVED = 2'd3
    } action_t;

    // Configuration register indexes.
    localparam logic [CfgIdxWidth-1:0] CFG_INPUT_RANGE      = 1'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_OVERSAMPLE_RATIO = 1'd1;

    // Oversampling code that the device does not support.
    localparam logic [2:0] OSR_INVALID = 3'd7;

    // Current configuration, from the register block to the sequencer.
    typedef struct packed {
        logic       input_range;
        logic [2:0] oversample_ratio;
    } cfg_t;

endpackage : dlar_pkg

`default_nettype wire

>>> rtl/dlar_if.sv
// Valid/ready channel interfaces of the dual-line ADC readout sequencer.
// One interface carries a pin-level input tick, the other a result tick.
// Depends on nothing.
`default_nettype none

interface dlar_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [1:0] device_select;
    logic [3:0] busy_lines;
    logic       dout_a;
    logic       dout_b;

    modport source (output valid, action, device_select, busy_lines, dout_a, dout_b,
                    input ready);
    modport sink (input valid, action, device_select, busy_lines, dout_a, dout_b,
                  output ready);
endinterface : dlar_in_if

interface dlar_out_if;
    logic        valid;
    logic        ready;
    logic        convert_n;
    logic [3:0]  chip_select_n;
    logic        serial_clock;
    logic        range_pin;
    logic [2:0]  oversample_pins;
    logic        pair_valid;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [4:0]  slot_index;
    logic        last_pair;
    logic        controller_busy;

    modport source (output valid, convert_n, chip_select_n, serial_clock, range_pin,
                    oversample_pins, pair_valid, word_a, word_b, slot_index,
                    last_pair, controller_busy,
                    input ready);
    modport sink (input valid, convert_n, chip_select_n, serial_clock, range_pin,
                  oversample_pins, pair_valid, word_a, word_b, slot_index,
                  last_pair, controller_busy,
                  output ready);
endinterface : dlar_out_if

`default_nettype wire

>>> rtl/dual_line_adc_readout_sequencer.sv
// Top level of the dual-line ADC readout sequencer: sequencer state machine,
// serial shift registers and the result register.
// Depends on dlar_pkg, dlar_if.sv and dlar_cfg_regs.
//
// Usage: every word on data_in is one tick of the ADC pin sequence: the busy
// lines, both serial data levels and an optional start action (all devices
// or one chosen device). For every accepted word exactly one result word
// appears on data_out with the pin levels for that tick (convert_n, chip
// selects, serial clock, range and oversampling pins) and, on the tick that
// completes a 16-bit pair, the two words with their slot index.
// The result of a word accepted at an edge is valid right after that edge.
// One word per cycle while the receiver takes results; the state update and
// the result are computed by one pass of logic from the state registers.
// A single result register parts the two channels: data_in is ready while
// that register is empty or being taken, so a stalled receiver holds the
// pending result and stops intake after one word, with nothing lost.
// Reset clears the sequencer to idle and the configuration to range 0 and
// oversampling code 0. Configuration is written through cfg_we, cfg_index
// and cfg_wdata, and takes effect on the next accepted word.
`default_nettype none

module dual_line_adc_readout_sequencer (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [dlar_pkg::CfgIdxWidth-1:0] cfg_index,
    input  wire logic [dlar_pkg::CfgWidth-1:0]    cfg_wdata,
    dlar_in_if.sink                               data_in,
    dlar_out_if.source                            data_out
);
    import dlar_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_LOW  = 2'd2,
        PH_HIGH = 2'd3
    } phase_t;

    typedef struct packed {
        logic        convert_n;
        logic [3:0]  chip_select_n;
        logic        serial_clock;
        logic        range_pin;
        logic [2:0]  oversample_pins;
        logic        pair_valid;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [4:0]  slot_index;
        logic        last_pair;
        logic        controller_busy;
    } result_t;

    localparam logic [2:0] DevCountL = 3'(DevCount);

    cfg_t cfg;

    phase_t      phase_reg, phase_next;
    logic        all_mode_reg, all_mode_next;
    logic [1:0]  device_reg, device_next;
    logic [1:0]  word_cnt_reg, word_cnt_next;
    logic [3:0]  bit_cnt_reg, bit_cnt_next;
    logic [15:0] shift_a_reg, shift_a_next;
    logic [15:0] shift_b_reg, shift_b_next;
    logic        out_valid_reg;
    result_t     result_reg, result_next;

    logic        accept;
    logic [3:0]  dev_cs;
    logic [15:0] bit_mask;
    action_t     act;

    dlar_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Intake runs whenever the result register is free or being emptied.
    assign data_in.ready = !out_valid_reg || data_out.ready;
    assign accept        = data_in.valid && data_in.ready;
    assign act           = action_t'(data_in.action);

    assign dev_cs   = ~(4'b0001 << device_reg);
    assign bit_mask = 16'h8000 >> bit_cnt_reg;

    // One tick of the sequencer: next state and the result for this tick.
    always_comb
    begin
        phase_next    = phase_reg;
        all_mode_next = all_mode_reg;
        device_next   = device_reg;
        word_cnt_next = word_cnt_reg;
        bit_cnt_next  = bit_cnt_reg;
        shift_a_next  = shift_a_reg;
        shift_b_next  = shift_b_reg;

        result_next                 = '0;
        result_next.convert_n       = 1'b1;
        result_next.chip_select_n   = 4'hF;
        result_next.serial_clock    = 1'b1;
        result_next.range_pin       = cfg.input_range;
        result_next.oversample_pins = cfg.oversample_ratio;
        result_next.controller_busy = 1'b1;

        unique case (phase_reg)
            PH_IDLE:
            begin
                result_next.controller_busy = 1'b0;
                if (act == ACT_START_ALL ||
                    (act == ACT_START_ONE && {1'b0, data_in.device_select} < DevCountL))
                begin
                    all_mode_next = (act == ACT_START_ALL);
                    device_next   = (act == ACT_START_ALL) ? 2'd0 : data_in.device_select;
                    word_cnt_next = 2'd0;
                    bit_cnt_next  = 4'd0;
                    phase_next    = PH_WAIT;
                    result_next.convert_n       = 1'b0;
                    result_next.controller_busy = 1'b1;
                end
            end
            PH_WAIT:
            begin
                if (!data_in.busy_lines[device_reg])
                begin
                    result_next.chip_select_n = dev_cs;
                    word_cnt_next = 2'd0;
                    bit_cnt_next  = 4'd0;
                    phase_next    = PH_LOW;
                end
            end
            PH_LOW:
            begin
                // Sample both lines while the serial clock is low.
                result_next.chip_select_n = dev_cs;
                result_next.serial_clock  = 1'b0;
                shift_a_next = (bit_cnt_reg == 4'd0) ? 16'h0000 : shift_a_reg;
                shift_b_next = (bit_cnt_reg == 4'd0) ? 16'h0000 : shift_b_reg;
                if (data_in.dout_a)
                begin
                    shift_a_next = shift_a_next | bit_mask;
                end
                if (data_in.dout_b)
                begin
                    shift_b_next = shift_b_next | bit_mask;
                end
                phase_next = PH_HIGH;
            end
            PH_HIGH:
            begin
                result_next.chip_select_n = dev_cs;
                if (bit_cnt_reg == 4'(WordBits - 1))
                begin
                    // Sixteenth bit done: report the pair.
                    result_next.pair_valid = 1'b1;
                    result_next.word_a     = shift_a_reg;
                    result_next.word_b     = shift_b_reg;
                    result_next.slot_index = all_mode_reg ? {device_reg, 1'b0, word_cnt_reg}
                                                          : {3'b000, word_cnt_reg};
                    bit_cnt_next = 4'd0;
                    if (word_cnt_reg == 2'(WordsPerDev - 1))
                    begin
                        word_cnt_next = 2'd0;
                        if (all_mode_reg && ({1'b0, device_reg} + 3'd1) < DevCountL)
                        begin
                            device_next = device_reg + 2'd1;
                            phase_next  = PH_WAIT;
                        end
                        else
                        begin
                            result_next.last_pair = 1'b1;
                            phase_next            = PH_IDLE;
                        end
                    end
                    else
                    begin
                        word_cnt_next = word_cnt_reg + 2'd1;
                        phase_next    = PH_LOW;
                    end
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg + 4'd1;
                    phase_next   = PH_LOW;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                result_next.controller_busy = 1'b0;
            end
        endcase
    end

    // Sequencer state, advanced once per accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            all_mode_reg <= 1'b0;
            device_reg   <= 2'd0;
            word_cnt_reg <= 2'd0;
            bit_cnt_reg  <= 4'd0;
            shift_a_reg  <= 16'h0000;
            shift_b_reg  <= 16'h0000;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            all_mode_reg <= all_mode_next;
            device_reg   <= device_next;
            word_cnt_reg <= word_cnt_next;
            bit_cnt_reg  <= bit_cnt_next;
            shift_a_reg  <= shift_a_next;
            shift_b_reg  <= shift_b_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (data_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded with each accepted word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign data_out.valid           = out_valid_reg;
    assign data_out.convert_n       = result_reg.convert_n;
    assign data_out.chip_select_n   = result_reg.chip_select_n;
    assign data_out.serial_clock    = result_reg.serial_clock;
    assign data_out.range_pin       = result_reg.range_pin;
    assign data_out.oversample_pins = result_reg.oversample_pins;
    assign data_out.pair_valid      = result_reg.pair_valid;
    assign data_out.word_a          = result_reg.word_a;
    assign data_out.word_b          = result_reg.word_b;
    assign data_out.slot_index      = result_reg.slot_index;
    assign data_out.last_pair       = result_reg.last_pair;
    assign data_out.controller_busy = result_reg.controller_busy;

endmodule : dual_line_adc_readout_sequencer

`default_nettype wire

>>> rtl/dlar_cfg_regs.sv
// Configuration registers of the dual-line ADC readout sequencer:
// range pin level and oversampling code, written through a plain write port.
// Depends on dlar_pkg.
`default_nettype none

module dlar_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [dlar_pkg::CfgIdxWidth-1:0] cfg_index,
    input  wire logic [dlar_pkg::CfgWidth-1:0]    cfg_wdata,
    output dlar_pkg::cfg_t                        cfg
);
    import dlar_pkg::*;

    cfg_t cfg_reg;

    // Register writes; an unsupported oversampling code leaves the old one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INPUT_RANGE:
                begin
                    cfg_reg.input_range <= cfg_wdata[0];
                end
                CFG_OVERSAMPLE_RATIO:
                begin
                    if (cfg_wdata[2:0] != OSR_INVALID)
                    begin
                        cfg_reg.oversample_ratio <= cfg_wdata[2:0];
                    end
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule : dlar_cfg_regs

`default_nettype wire

>>> tb/dual_line_adc_readout_sequencer_tb.sv
// Self-checking testbench for the dual-line ADC readout sequencer.
// Drives pin-level ticks, checks each result word against a table row or a sequencer model.
// Depends on dlar_pkg, the channel interfaces in dlar_if.sv and the sequencer RTL.
`default_nettype none

module dual_line_adc_readout_sequencer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dlar_pkg::*;

    // One input word: the pin levels and the action for one tick.
    typedef struct packed {
        action_t    action;
        logic [1:0] device_select;
        logic [3:0] busy_lines;
        logic       dout_a;
        logic       dout_b;
    } tick_t;

    // One result word: every output pin and the finished pair.
    typedef struct packed {
        logic        convert_n;
        logic [3:0]  chip_select_n;
        logic        serial_clock;
        logic        range_pin;
        logic [2:0]  oversample_pins;
        logic        pair_valid;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [4:0]  slot_index;
        logic        last_pair;
        logic        controller_busy;
    } pins_t;

    // A row of the directed table; the tick is repeated reps times.
    typedef struct {
        tick_t tick;
        int    reps;
        bit    typed;
        pins_t want;
    } vector_row_t;

    // Sequencer phases of the model.
    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_WAIT,
        SQ_CLK_LOW,
        SQ_CLK_HIGH
    } seq_phase_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CfgIdxWidth-1:0] cfg_index;
    logic [CfgWidth-1:0] cfg_wdata;

    dlar_in_if  in_if ();
    dlar_out_if out_if ();

    dual_line_adc_readout_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .data_in   (in_if),
        .data_out  (out_if)
    );

    // Model state of the sequencer and its configuration.
    seq_phase_t  sq_phase = SQ_IDLE;
    logic        sq_all_mode = 1'b0;
    logic [1:0]  sq_device = 2'd0;
    logic [1:0]  sq_word = 2'd0;
    logic [3:0]  sq_bit = 4'd0;
    logic [15:0] sq_shift_a = 16'd0;
    logic [15:0] sq_shift_b = 16'd0;
    logic        cfg_range = 1'b0;
    logic [2:0]  cfg_osr = 3'd0;

    pins_t pin_levels_q[$];
    int    error_count = 0;
    int    burst_left = 0;

    // Typed expectation that travels with the word being driven.
    bit    pending_typed;
    pins_t pending_want;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Hard limit on the run time.
    initial
    begin
        #10_000_000;
        $display("** dual_line_adc_readout_sequencer: FAILED **");
        $finish;
    end

    task automatic report_error(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        error_count++;
    endtask

    // Computes the pin levels for one tick and advances the model state.
    function automatic pins_t predict_pins(input tick_t t);
        pins_t      r;
        logic [3:0] dev_cs;
        r = '0;
        r.convert_n = 1'b1;
        r.chip_select_n = 4'hF;
        r.serial_clock = 1'b1;
        r.range_pin = cfg_range;
        r.oversample_pins = cfg_osr;
        r.controller_busy = 1'b1;
        dev_cs = 4'hF & ~(4'b0001 << sq_device);
        case (sq_phase)
            SQ_IDLE:
            begin
                r.controller_busy = 1'b0;
                if (t.action == ACT_START_ALL || (t.action == ACT_START_ONE
                        && int'(t.device_select) < DevCount))
                begin
                    sq_all_mode = (t.action == ACT_START_ALL);
                    sq_device = (t.action == ACT_START_ALL) ? 2'd0 : t.device_select;
                    sq_word = 2'd0;
                    sq_bit = 4'd0;
                    sq_phase = SQ_WAIT;
                    r.convert_n = 1'b0;
                    r.controller_busy = 1'b1;
                end
            end
            SQ_WAIT:
            begin
                if (!t.busy_lines[sq_device])
                begin
                    r.chip_select_n = dev_cs;
                    sq_word = 2'd0;
                    sq_bit = 4'd0;
                    sq_phase = SQ_CLK_LOW;
                end
            end
            SQ_CLK_LOW:
            begin
                r.chip_select_n = dev_cs;
                r.serial_clock = 1'b0;
                if (sq_bit == 4'd0)
                begin
                    sq_shift_a = 16'd0;
                    sq_shift_b = 16'd0;
                end
                // Data arrives MSB first.
                if (t.dout_a)
                    sq_shift_a[15 - sq_bit] = 1'b1;
                if (t.dout_b)
                    sq_shift_b[15 - sq_bit] = 1'b1;
                sq_phase = SQ_CLK_HIGH;
            end
            SQ_CLK_HIGH:
            begin
                r.chip_select_n = dev_cs;
                if (sq_bit == 4'd15)
                begin
                    r.pair_valid = 1'b1;
                    r.word_a = sq_shift_a;
                    r.word_b = sq_shift_b;
                    r.slot_index = (sq_all_mode ? {sq_device, 3'b000} : 5'd0) + sq_word;
                    sq_bit = 4'd0;
                    if (sq_word == 2'd3)
                    begin
                        sq_word = 2'd0;
                        if (sq_all_mode && int'(sq_device) + 1 < DevCount)
                        begin
                            sq_device = sq_device + 2'd1;
                            sq_phase = SQ_WAIT;
                        end
                        else
                        begin
                            r.last_pair = 1'b1;
                            sq_phase = SQ_IDLE;
                        end
                    end
                    else
                    begin
                        sq_word = sq_word + 2'd1;
                        sq_phase = SQ_CLK_LOW;
                    end
                end
                else
                begin
                    sq_bit = sq_bit + 4'd1;
                    sq_phase = SQ_CLK_LOW;
                end
            end
        endcase
        return r;
    endfunction

    task automatic compare_pins(input pins_t got, input pins_t want);
        if (got.convert_n !== want.convert_n)
            report_error($sformatf("convert_n got %0h, expected %0h",
                                   got.convert_n, want.convert_n));
        if (got.chip_select_n !== want.chip_select_n)
            report_error($sformatf("chip_select_n got %0h, expected %0h",
                                   got.chip_select_n, want.chip_select_n));
        if (got.serial_clock !== want.serial_clock)
            report_error($sformatf("serial_clock got %0h, expected %0h",
                                   got.serial_clock, want.serial_clock));
        if (got.range_pin !== want.range_pin)
            report_error($sformatf("range_pin got %0h, expected %0h",
                                   got.range_pin, want.range_pin));
        if (got.oversample_pins !== want.oversample_pins)
            report_error($sformatf("oversample_pins got %0h, expected %0h",
                                   got.oversample_pins, want.oversample_pins));
        if (got.pair_valid !== want.pair_valid)
            report_error($sformatf("pair_valid got %0h, expected %0h",
                                   got.pair_valid, want.pair_valid));
        if (got.word_a !== want.word_a)
            report_error($sformatf("word_a got %0h, expected %0h", got.word_a, want.word_a));
        if (got.word_b !== want.word_b)
            report_error($sformatf("word_b got %0h, expected %0h", got.word_b, want.word_b));
        if (got.slot_index !== want.slot_index)
            report_error($sformatf("slot_index got %0d, expected %0d",
                                   got.slot_index, want.slot_index));
        if (got.last_pair !== want.last_pair)
            report_error($sformatf("last_pair got %0h, expected %0h",
                                   got.last_pair, want.last_pair));
        if (got.controller_busy !== want.controller_busy)
            report_error($sformatf("controller_busy got %0h, expected %0h",
                                   got.controller_busy, want.controller_busy));
    endtask

    // Watches both channels and the configuration port at every edge.
    always @(posedge clk)
    begin : monitor
        tick_t t;
        pins_t got;
        pins_t predicted;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_INPUT_RANGE)
                    cfg_range = cfg_wdata[0];
                else if (cfg_index == CFG_OVERSAMPLE_RATIO && cfg_wdata != OSR_INVALID)
                    cfg_osr = cfg_wdata;
            end
            if (in_if.valid && in_if.ready)
            begin
                t.action = action_t'(in_if.action);
                t.device_select = in_if.device_select;
                t.busy_lines = in_if.busy_lines;
                t.dout_a = in_if.dout_a;
                t.dout_b = in_if.dout_b;
                predicted = predict_pins(t);
                pin_levels_q.push_back(pending_typed ? pending_want : predicted);
            end
            if (out_if.valid && out_if.ready)
            begin
                got.convert_n = out_if.convert_n;
                got.chip_select_n = out_if.chip_select_n;
                got.serial_clock = out_if.serial_clock;
                got.range_pin = out_if.range_pin;
                got.oversample_pins = out_if.oversample_pins;
                got.pair_valid = out_if.pair_valid;
                got.word_a = out_if.word_a;
                got.word_b = out_if.word_b;
                got.slot_index = out_if.slot_index;
                got.last_pair = out_if.last_pair;
                got.controller_busy = out_if.controller_busy;
                if (pin_levels_q.size() == 0)
                    report_error("result word arrived with nothing expected");
                else
                    compare_pins(got, pin_levels_q.pop_front());
            end
        end
    end

    // Receiver: free-running, choppy and blocked stretches of random length.
    initial
    begin : receiver
        int left;
        int mode;
        out_if.ready = 1'b0;
        left = 0;
        mode = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 2);
                left = (mode == 2) ? $urandom_range(1, 20) : $urandom_range(5, 60);
            end
            left--;
            out_if.ready <= (mode == 0) ? 1'b1 : ((mode == 1) ? 1'($urandom) : 1'b0);
        end
    end

    // Drives one word and holds it until it is accepted.
    task automatic send_tick(input tick_t t, input bit typed, input pins_t want);
        in_if.valid <= 1'b1;
        in_if.action <= t.action;
        in_if.device_select <= t.device_select;
        in_if.busy_lines <= t.busy_lines;
        in_if.dout_a <= t.dout_a;
        in_if.dout_b <= t.dout_b;
        pending_typed <= typed;
        pending_want <= want;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
    endtask

    // Sends a word inside a burst; a new burst starts after a random gap.
    task automatic send_paced(input tick_t t, input bit typed, input pins_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        send_tick(t, typed, want);
    endtask

    // Stops the sender and waits until every expected word has come.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pin_levels_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CfgIdxWidth-1:0] idx,
                             input logic [CfgWidth-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic pins_t fixed_pins(input logic conv, input logic [3:0] cs,
                                         input logic cbusy);
        pins_t r;
        r = '0;
        r.convert_n = conv;
        r.chip_select_n = cs;
        r.serial_clock = 1'b1;
        r.controller_busy = cbusy;
        return r;
    endfunction

    function automatic vector_row_t mk_row(input action_t act, input logic [1:0] sel,
                                           input logic [3:0] busy, input logic da,
                                           input logic db, input int reps,
                                           input bit typed, input pins_t want);
        vector_row_t row;
        row.tick.action = act;
        row.tick.device_select = sel;
        row.tick.busy_lines = busy;
        row.tick.dout_a = da;
        row.tick.dout_b = db;
        row.reps = reps;
        row.typed = typed;
        row.want = want;
        return row;
    endfunction

    // Random tick: starts are likely while the sequencer is idle, rare otherwise.
    function automatic tick_t random_tick();
        tick_t t;
        int    roll;
        roll = $urandom_range(0, 99);
        if (sq_phase == SQ_IDLE)
            t.action = (roll < 40) ? ACT_START_ALL : (roll < 80) ? ACT_START_ONE :
                       (roll < 95) ? ACT_TICK : ACT_RESERVED;
        else
            t.action = (roll < 3) ? ACT_START_ALL : (roll < 6) ? ACT_START_ONE :
                       (roll < 8) ? ACT_RESERVED : ACT_TICK;
        t.device_select = 2'($urandom);
        // Busy mostly low so the waits end soon; now and then all devices busy.
        t.busy_lines = ($urandom_range(0, 19) == 0) ? 4'hF : 4'($urandom & $urandom);
        t.dout_a = 1'($urandom);
        t.dout_b = 1'($urandom);
        return t;
    endfunction

    // Stimulus: directed table at reset settings, then random phases.
    initial
    begin : stimulus
        vector_row_t vectors[$];
        logic [2:0]  range_plan[0:3];
        logic [2:0]  osr_plan[0:3];
        pins_t       idle_word;
        pins_t       wait_word;
        pins_t       none;
        int          guard;

        range_plan = '{3'd1, 3'd0, 3'd3, 3'd2};
        osr_plan = '{3'd6, OSR_INVALID, 3'd0, 3'd3};
        idle_word = fixed_pins(1'b1, 4'hF, 1'b0);
        wait_word = fixed_pins(1'b1, 4'hF, 1'b1);
        none = '0;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_if.valid = 1'b0;
        in_if.action = ACT_TICK;
        in_if.device_select = 2'd0;
        in_if.busy_lines = 4'd0;
        in_if.dout_a = 1'b0;
        in_if.dout_b = 1'b0;
        pending_typed = 1'b0;
        pending_want = '0;

        // Idle ticks, the reserved action and a one-device run of the last device.
        vectors.push_back(mk_row(ACT_TICK, 2'd0, 4'h0, 1'b0, 1'b0, 1, 1'b1, idle_word));
        vectors.push_back(mk_row(ACT_RESERVED, 2'd3, 4'hF, 1'b1, 1'b1, 1, 1'b1, idle_word));
        vectors.push_back(mk_row(ACT_TICK, 2'd3, 4'hF, 1'b0, 1'b1, 2, 1'b1, idle_word));
        vectors.push_back(mk_row(ACT_START_ONE, 2'd3, 4'hF, 1'b0, 1'b0, 1, 1'b1,
                                 fixed_pins(1'b0, 4'hF, 1'b1)));
        // Starts while running are ignored; device 3 is still converting.
        vectors.push_back(mk_row(ACT_START_ALL, 2'd0, 4'h8, 1'b0, 1'b0, 1, 1'b1, wait_word));
        vectors.push_back(mk_row(ACT_START_ONE, 2'd0, 4'h8, 1'b1, 1'b1, 3, 1'b1, wait_word));
        vectors.push_back(mk_row(ACT_TICK, 2'd0, 4'h7, 1'b0, 1'b0, 1, 1'b1,
                                 fixed_pins(1'b1, 4'h7, 1'b1)));
        // Extreme data: all ones on one line and all zeros on the other, then all ones on both.
        vectors.push_back(mk_row(ACT_TICK, 2'd0, 4'hF, 1'b1, 1'b0, 32, 1'b0, none));
        vectors.push_back(mk_row(ACT_TICK, 2'd0, 4'hF, 1'b0, 1'b1, 32, 1'b0, none));
        vectors.push_back(mk_row(ACT_TICK, 2'd0, 4'hF, 1'b1, 1'b1, 64, 1'b0, none));
        vectors.push_back(mk_row(ACT_TICK, 2'd0, 4'h0, 1'b0, 1'b0, 1, 1'b1, idle_word));
        // All-devices run; the random part finishes it.
        vectors.push_back(mk_row(ACT_START_ALL, 2'd2, 4'h0, 1'b1, 1'b1, 1, 1'b1,
                                 fixed_pins(1'b0, 4'hF, 1'b1)));
        vectors.push_back(mk_row(ACT_TICK, 2'd0, 4'hE, 1'b0, 1'b0, 1, 1'b1,
                                 fixed_pins(1'b1, 4'hE, 1'b1)));
        vectors.push_back(mk_row(ACT_TICK, 2'd0, 4'h0, 1'b0, 1'b0, 128, 1'b0, none));
        vectors.push_back(mk_row(ACT_TICK, 2'd1, 4'h2, 1'b1, 1'b0, 2, 1'b1, wait_word));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (vectors[i])
        begin
            repeat (vectors[i].reps)
                send_paced(vectors[i].tick, vectors[i].typed, vectors[i].want);
        end

        // Random phases, each after a configuration change with the block drained.
        for (int p = 0; p < 6; p++)
        begin
            drain_results();
            if (p < 4)
            begin
                write_cfg(CFG_INPUT_RANGE, range_plan[p]);
                write_cfg(CFG_OVERSAMPLE_RATIO, osr_plan[p]);
            end
            else
            begin
                write_cfg(CFG_OVERSAMPLE_RATIO, 3'($urandom));
                write_cfg(CFG_INPUT_RANGE, 3'($urandom));
            end
            burst_left = 0;
            repeat (205)
                send_paced(random_tick(), 1'b0, none);
        end

        // Wait for the last words, then for any stray results.
        in_if.valid <= 1'b0;
        guard = 0;
        while (pin_levels_q.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (pin_levels_q.size() != 0)
            report_error($sformatf("%0d result words never arrived", pin_levels_q.size()));
        if (error_count == 0)
            $display("** dual_line_adc_readout_sequencer: PASSED **");
        else
            $display("** dual_line_adc_readout_sequencer: FAILED **");
        $finish;
    end

endmodule : dual_line_adc_readout_sequencer_tb

`default_nettype wire
